@@ rtl/sldfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sldfr_pkg
// Shared constants and controller/datapath types for the sync/length/XOR
// frame receiver.
// ----------------------------------------------------------------------------
package sldfr_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);

    localparam logic [7:0] SYNC_FIRST       = 8'h4C;
    localparam logic [7:0] SYNC_SECOND      = 8'h4D;
    localparam logic [7:0] EXCEPTION_BYTE   = 8'h01;
    localparam logic [5:0] MAX_LENGTH_RESET = 6'd40;

    typedef struct packed {
        logic load_len;
        logic store_byte;
        logic start_emit;
        logic next_emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_sync1;
        logic is_sync2;
        logic len_ok;
        logic more_payload;
        logic payload_empty;
        logic frame_good;
        logic emit_last;
    } t_dp_status;

endpackage

@@ rtl/sldfr_in_if.sv @@
// ----------------------------------------------------------------------------
// sldfr_in_if
// Received byte channel: valid/ready handshake with one serial byte.
// ----------------------------------------------------------------------------
interface sldfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/sldfr_out_if.sv @@
// ----------------------------------------------------------------------------
// sldfr_out_if
// Payload byte channel: valid/ready handshake with one payload byte and tags.
// ----------------------------------------------------------------------------
interface sldfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       is_last;
    logic [5:0] frame_length;
    logic       checksum_ok;

    modport source (output valid, output payload_byte, output byte_index,
                    output is_last, output frame_length, output checksum_ok,
                    input ready);
    modport sink   (input valid, input payload_byte, input byte_index,
                    input is_last, input frame_length, input checksum_ok,
                    output ready);
endinterface

@@ rtl/sync_length_xor_deframer.sv @@
// ----------------------------------------------------------------------------
// sync_length_xor_deframer
// Hunts for sync 0x4C 0x4D, takes a length byte, stores the payload, checks
// the XOR checksum and emits the payload bytes of accepted frames.
// ----------------------------------------------------------------------------
//  channel  | dir | fields
//  i_rx     | in  | rx_byte[7:0]
//  o_frm    | out | payload_byte[7:0] byte_index[5:0] is_last frame_length[5:0]
//           |     | checksum_ok
//  i_cfg_*  | in  | max_length[5:0], write enable only
//
// One received byte per cycle while hunting, reading length or collecting.
// An accepted frame emits each payload byte with a RAM read, then an output
// transfer; i_rx.ready is low for the whole burst.
// Synchronous active-low reset; max_length resets to 40. No clearing pass.
// A stalled o_frm holds its byte and the controller waits.
// ----------------------------------------------------------------------------
module sync_length_xor_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    sldfr_in_if.sink    i_rx,
    sldfr_out_if.source o_frm
);
    import sldfr_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    sldfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rx.valid),
        .o_in_ready  (i_rx.ready),
        .o_out_valid (o_frm.valid),
        .i_out_ready (o_frm.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sldfr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_rx_byte      (i_rx.rx_byte),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_payload_byte (o_frm.payload_byte),
        .o_byte_index   (o_frm.byte_index),
        .o_is_last      (o_frm.is_last),
        .o_frame_length (o_frm.frame_length),
        .o_checksum_ok  (o_frm.checksum_ok)
    );

endmodule

@@ rtl/sldfr_ram.sv @@
// ----------------------------------------------------------------------------
// sldfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sldfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sldfr_dp.sv @@
// ----------------------------------------------------------------------------
// sldfr_dp
// Datapath: length/limit register, payload store, running XOR, emit counter
// and the output tags.
// ----------------------------------------------------------------------------
module sldfr_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [5:0]             i_cfg_wdata,
    input  logic [7:0]             i_rx_byte,
    input  sldfr_pkg::t_dp_cmd     i_cmd,
    output sldfr_pkg::t_dp_status  o_status,
    output logic [7:0]             o_payload_byte,
    output logic [5:0]             o_byte_index,
    output logic                   o_is_last,
    output logic [5:0]             o_frame_length,
    output logic                   o_checksum_ok
);
    import sldfr_pkg::*;

    logic [5:0] r_max_len;
    logic [5:0] r_len;
    logic [5:0] r_count;
    logic [7:0] r_xor;
    logic [7:0] r_first;
    logic       r_ok;
    logic [5:0] r_emit_idx;

    logic [5:0] payload_len;
    logic       wr_in_range;
    logic       rd_in_range;
    logic [7:0] ram_rdata;

    assign payload_len = (r_len == 6'd0) ? 6'd0 : r_len - 6'd1;
    assign wr_in_range = (32'(r_count) < BUFFER_DEPTH);
    assign rd_in_range = (32'(r_emit_idx) < BUFFER_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LENGTH_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_count    <= '0;
            r_xor      <= '0;
            r_emit_idx <= '0;
        end else begin
            if (i_cmd.load_len) begin
                r_len   <= i_rx_byte[5:0];
                r_count <= '0;
                r_xor   <= '0;
            end
            if (i_cmd.store_byte) begin
                r_xor   <= r_xor ^ i_rx_byte;
                r_count <= r_count + 6'd1;
            end
            if (i_cmd.start_emit) begin
                r_emit_idx <= '0;
            end
            if (i_cmd.next_emit) begin
                r_emit_idx <= r_emit_idx + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_byte && r_count == 6'd0) begin
            r_first <= i_rx_byte;
        end
        if (i_cmd.start_emit) begin
            r_ok <= (i_rx_byte == r_xor);
        end
    end

    sldfr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store_byte && wr_in_range),
        .i_waddr (ADDR_W'(r_count)),
        .i_wdata (i_rx_byte),
        .i_raddr (ADDR_W'(r_emit_idx)),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_status.is_sync1      = (i_rx_byte == SYNC_FIRST);
        o_status.is_sync2      = (i_rx_byte == SYNC_SECOND);
        o_status.len_ok        = (i_rx_byte <= {2'b00, r_max_len});
        o_status.more_payload  = (r_count < payload_len);
        o_status.payload_empty = (payload_len == 6'd0);
        o_status.frame_good    = (i_rx_byte == r_xor) || (r_first == EXCEPTION_BYTE);
        o_status.emit_last     = (r_emit_idx + 6'd1 == payload_len);
    end

    assign o_payload_byte = rd_in_range ? ram_rdata : 8'h00;
    assign o_byte_index   = r_emit_idx;
    assign o_is_last      = o_status.emit_last;
    assign o_frame_length = r_len;
    assign o_checksum_ok  = r_ok;

endmodule

@@ rtl/sldfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// sldfr_ctrl
// Controller: sync hunt, length check, payload collection and emit sequencing.
// ----------------------------------------------------------------------------
module sldfr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  sldfr_pkg::t_dp_status i_status,
    output sldfr_pkg::t_dp_cmd    o_cmd
);
    import sldfr_pkg::*;

    localparam logic [2:0] S_HUNT1   = 3'd0;
    localparam logic [2:0] S_HUNT2   = 3'd1;
    localparam logic [2:0] S_LEN     = 3'd2;
    localparam logic [2:0] S_COLLECT = 3'd3;
    localparam logic [2:0] S_RD      = 3'd4;
    localparam logic [2:0] S_OUT     = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       in_xfer;
    logic       out_xfer;

    assign o_in_ready  = (r_state == S_HUNT1) || (r_state == S_HUNT2) ||
                         (r_state == S_LEN) || (r_state == S_COLLECT);
    assign o_out_valid = (r_state == S_OUT);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_xfer    = o_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_HUNT1: begin
                if (in_xfer && i_status.is_sync1) n_state = S_HUNT2;
            end
            S_HUNT2: begin
                if (in_xfer) n_state = i_status.is_sync2 ? S_LEN : S_HUNT1;
            end
            S_LEN: begin
                if (in_xfer) begin
                    o_cmd.load_len = 1'b1;
                    n_state        = i_status.len_ok ? S_COLLECT : S_HUNT1;
                end
            end
            S_COLLECT: begin
                if (in_xfer) begin
                    if (i_status.more_payload) begin
                        o_cmd.store_byte = 1'b1;
                    end else if (!i_status.payload_empty && i_status.frame_good) begin
                        o_cmd.start_emit = 1'b1;
                        n_state          = S_RD;
                    end else begin
                        n_state = S_HUNT1;
                    end
                end
            end
            S_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_xfer) begin
                    if (i_status.emit_last) begin
                        n_state = S_HUNT1;
                    end else begin
                        o_cmd.next_emit = 1'b1;
                        n_state         = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_HUNT1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT1;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/sldfr_checker.sv @@
// ----------------------------------------------------------------------------
// sldfr_checker
// Port-level assertions for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module sldfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_payload_byte,
    input logic [5:0] i_byte_index,
    input logic       i_is_last,
    input logic [5:0] i_frame_length
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_payload_byte) && $stable(i_byte_index))
        else $error("stalled output changed");

    a_no_rx_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready during payload burst");

    a_last_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_is_last == ({1'b0, i_byte_index} + 7'd2 == {1'b0, i_frame_length})))
        else $error("last flag does not match index and length");

    a_next_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_is_last |-> ##2
            (i_out_valid && i_byte_index == $past(i_byte_index, 2) + 6'd1 &&
             $stable(i_frame_length)))
        else $error("payload burst skipped or repeated a byte");

    a_end_of_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_is_last |=> !i_out_valid && i_in_ready)
        else $error("burst did not end after last byte");

endmodule

bind sync_length_xor_deframer sldfr_checker u_sldfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_rx.ready),
    .i_out_valid    (o_frm.valid),
    .i_out_ready    (o_frm.ready),
    .i_payload_byte (o_frm.payload_byte),
    .i_byte_index   (o_frm.byte_index),
    .i_is_last      (o_frm.is_last),
    .i_frame_length (o_frm.frame_length)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sync_length_xor_deframer. Feeds received bytes
// through the input channel with bursty timing, mirrors the frame receiver
// in a local predictor and checks every payload transfer in order against
// the predicted bytes. Covers sync hunting, length limits, checksum accept,
// reject and the 0x01 override, empty frames, back-pressure and random
// traffic.
// ----------------------------------------------------------------------------
module tb;
    import sldfr_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 400;

    typedef enum logic [1:0] {
        HUNT_SYNC1,
        HUNT_SYNC2,
        READ_LENGTH,
        COLLECT
    } t_hunt_phase;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [5:0] byte_index;
        logic       is_last;
        logic [5:0] frame_length;
        logic       checksum_ok;
    } t_frm_byte;

    typedef logic [7:0] t_byte_q[$];

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [5:0] cfg_wdata;

    sldfr_in_if  rx_if();
    sldfr_out_if frm_if();

    sync_length_xor_deframer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_rx        (rx_if),
        .o_frm       (frm_if)
    );

    // predictor state
    t_hunt_phase rx_phase;
    logic [5:0]  max_len;
    logic [7:0]  decl_len;
    logic [5:0]  stored;
    logic [7:0]  run_xor;
    logic [7:0]  payload_copy [BUFFER_DEPTH];
    t_frm_byte   due_bytes[$];

    int unsigned failures;
    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned sender_gap_max;
    int unsigned stall_pct;
    int unsigned hold_request;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    task automatic deframe_byte(input logic [7:0] b);
        int unsigned plen;
        logic        good;
        t_frm_byte   r;
        case (rx_phase)
            HUNT_SYNC1: rx_phase = (b == SYNC_FIRST) ? HUNT_SYNC2 : HUNT_SYNC1;
            HUNT_SYNC2: rx_phase = (b == SYNC_SECOND) ? READ_LENGTH : HUNT_SYNC1;
            READ_LENGTH: begin
                decl_len = b;
                stored   = '0;
                run_xor  = '0;
                rx_phase = (b > {2'b00, max_len}) ? HUNT_SYNC1 : COLLECT;
            end
            default: begin
                plen = (decl_len >= 1) ? decl_len - 1 : 0;
                if (stored < plen) begin
                    if (stored < BUFFER_DEPTH)
                        payload_copy[stored] = b;
                    run_xor = run_xor ^ b;
                    stored  = stored + 6'd1;
                end else begin
                    if (plen != 0) begin
                        good = (b == run_xor);
                        if (good || payload_copy[0] == EXCEPTION_BYTE) begin
                            for (int unsigned k = 0; k < plen; k++) begin
                                r.payload_byte = (k < BUFFER_DEPTH) ? payload_copy[k] : 8'h00;
                                r.byte_index   = 6'(k);
                                r.is_last      = (k + 1 == plen);
                                r.frame_length = decl_len[5:0];
                                r.checksum_ok  = good;
                                due_bytes.push_back(r);
                            end
                        end
                    end
                    rx_phase = HUNT_SYNC1;
                    stored   = '0;
                    run_xor  = '0;
                end
            end
        endcase
    endtask

    // one received byte; the prediction is made at the accepting edge
    task automatic send_rx(input logic [7:0] b);
        int unsigned gap;
        @(negedge clk);
        if (burst_left == 0) begin
            gap = (sender_gap_max > 0) ? $urandom_range(1, sender_gap_max) : 0;
            if (gap > 0) begin
                rx_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
        deframe_byte(b);
        burst_left--;
    endtask

    task automatic send_frame(input logic [7:0] length, input t_byte_q body,
                              input logic [7:0] flip);
        logic [7:0] sum;
        sum = '0;
        send_rx(SYNC_FIRST);
        send_rx(SYNC_SECOND);
        send_rx(length);
        foreach (body[i]) begin
            send_rx(body[i]);
            sum = sum ^ body[i];
        end
        send_rx(sum ^ flip);
    endtask

    function automatic t_byte_q random_body(input int unsigned n);
        t_byte_q q;
        repeat (n) q.push_back(8'($urandom));
        return q;
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        rx_if.valid <= 1'b0;
        burst_left = 0;
        while (due_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [5:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        max_len = value;
    endtask

    // receiver: run/stall stretches plus an optional long hold-off
    initial begin : receiver
        int unsigned run_left;
        int unsigned stall_left;
        int unsigned hold_left;
        frm_if.ready = 1'b0;
        run_left   = 0;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                frm_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_pct == 0) begin
                frm_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                frm_if.ready <= 1'b0;
                stall_left--;
            end else if (run_left > 0) begin
                frm_if.ready <= 1'b1;
                run_left--;
            end else begin
                run_left   = $urandom_range(0, 8);
                stall_left = ($urandom_range(0, 99) < stall_pct) ? $urandom_range(1, 6) : 0;
                frm_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : check_frm
        t_frm_byte want;
        if (rst_n && frm_if.valid && frm_if.ready) begin
            if (due_bytes.size() == 0) begin
                $error("unexpected payload transfer: payload_byte %0h byte_index %0d",
                       frm_if.payload_byte, frm_if.byte_index);
                failures++;
            end else begin
                want = due_bytes.pop_front();
                if (frm_if.payload_byte !== want.payload_byte) begin
                    $error("payload_byte: expected %0h, got %0h",
                           want.payload_byte, frm_if.payload_byte);
                    failures++;
                end
                if (frm_if.byte_index !== want.byte_index) begin
                    $error("byte_index: expected %0d, got %0d",
                           want.byte_index, frm_if.byte_index);
                    failures++;
                end
                if (frm_if.is_last !== want.is_last) begin
                    $error("is_last: expected %0b, got %0b", want.is_last, frm_if.is_last);
                    failures++;
                end
                if (frm_if.frame_length !== want.frame_length) begin
                    $error("frame_length: expected %0d, got %0d",
                           want.frame_length, frm_if.frame_length);
                    failures++;
                end
                if (frm_if.checksum_ok !== want.checksum_ok) begin
                    $error("checksum_ok: expected %0b, got %0b",
                           want.checksum_ok, frm_if.checksum_ok);
                    failures++;
                end
            end
        end
    end

    task automatic test_sync_hunt();
        t_byte_q body;
        sender_gap_max = 3;
        stall_pct      = 30;
        // a repeated first sync is not taken as a new start; the hunt falls back to the first sync byte
        send_rx(SYNC_FIRST);
        send_rx(SYNC_FIRST);
        send_rx(SYNC_SECOND);
        send_rx(SYNC_FIRST);
        send_rx(8'h55);
        body = {8'h7E};
        send_frame(8'd2, body, 8'h00);
    endtask

    task automatic test_frame_checks();
        t_byte_q body;
        body = {8'h00, 8'hFF, SYNC_FIRST};
        send_frame(8'd4, body, 8'h00);
        body = {8'h02};
        send_frame(8'd2, body, 8'h80);
        body = {EXCEPTION_BYTE, 8'h5A};
        send_frame(8'd3, body, 8'h33);
        body.delete();
        send_frame(8'd0, body, 8'h00);
        send_frame(8'd1, body, 8'hA5);
        send_frame(8'hFF, body, 8'h00);
    endtask

    task automatic test_length_limits();
        t_byte_q none;
        send_frame(8'(MAX_LENGTH_RESET + 1), none, 8'h00);
        wait_idle();
        write_max_length(6'd2);
        send_frame(8'd2, random_body(1), 8'h00);
        send_frame(8'd3, none, 8'h00);
        wait_idle();
        write_max_length(6'd63);
        send_frame(8'd64, none, 8'h00);
    endtask

    // longest frame under a long hold-off; the next frame waits at the input
    task automatic test_back_pressure();
        wait_idle();
        sender_gap_max = 0;
        stall_pct      = 0;
        hold_request   = HOLD_CYCLES;
        send_frame(8'd63, random_body(62), 8'h00);
        send_frame(8'd2, random_body(1), 8'h00);
    endtask

    task automatic run_random_phase(input logic [5:0] limit, input int unsigned n_items,
                                    input int unsigned gap, input int unsigned stall);
        t_byte_q     body;
        int unsigned sent;
        int unsigned plen;
        int unsigned kind;
        logic [7:0]  b;
        logic [7:0]  flip;
        wait_idle();
        write_max_length(limit);
        sender_gap_max = gap;
        stall_pct      = stall;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            body.delete();
            case (kind)
                0: begin
                    plen = $urandom_range(1, 4);
                    repeat (plen) send_rx(8'($urandom));
                    sent += plen;
                end
                1: begin
                    b = 8'($urandom);
                    if (b == SYNC_SECOND)
                        b = SYNC_FIRST;
                    send_rx(SYNC_FIRST);
                    send_rx(b);
                    sent += 2;
                end
                2: begin
                    send_frame(8'($urandom_range(limit + 1, 255)), body, 8'h00);
                    sent += 4;
                end
                3: begin
                    send_frame(8'($urandom_range(0, 1)), body, 8'($urandom));
                    sent += 4;
                end
                default: begin
                    if ($urandom_range(0, 9) == 0)
                        plen = $urandom_range(1, limit - 1);
                    else
                        plen = $urandom_range(1, (limit > 9) ? 8 : limit - 1);
                    body = random_body(plen);
                    if ($urandom_range(0, 3) == 0)
                        body[0] = EXCEPTION_BYTE;
                    flip = ($urandom_range(0, 9) < 7) ? 8'h00 : 8'($urandom_range(1, 255));
                    send_frame(8'(plen + 1), body, flip);
                    sent += plen + 4;
                end
            endcase
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(6'd12, 10, 4, 30);
    endtask

    initial begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        failures       = 0;
        burst_left     = 0;
        sender_gap_max = 0;
        stall_pct      = 0;
        hold_request   = 0;
        rx_phase = HUNT_SYNC1;
        max_len  = MAX_LENGTH_RESET;
        decl_len = '0;
        stored   = '0;
        run_xor  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_sync_hunt();
        test_frame_checks();
        test_length_limits();
        test_back_pressure();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
